### rtl/gcf_pkg.sv
// ----------------------------------------------------------------------------
// gcf_pkg
// shared types, constants and helpers of the 3x3 grayscale convolution filter
// ----------------------------------------------------------------------------
package gcf_pkg;

    localparam int unsigned PIX_W          = 8;
    localparam int unsigned POS_W          = 11;
    localparam int unsigned DIM_W          = 12;
    localparam int unsigned COEF_W         = 16;
    localparam int unsigned COEF_FRAC_BITS = 12;
    localparam int unsigned KROW_W         = 3 * COEF_W;
    localparam int unsigned CFG_DATA_W     = KROW_W;
    localparam int unsigned CFG_ADDR_W     = 3;
    localparam int unsigned PROD_W         = COEF_W + PIX_W;
    localparam int unsigned ACC_W          = PROD_W + 5;
    localparam int unsigned NUM_TAPS       = 9;

    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned COUNT_LIMIT    = 2048;

    localparam int unsigned BIAS_LEVEL     = 127;
    localparam int unsigned LEVEL_MAX      = 255;
    localparam int unsigned BIAS_FIXED     = BIAS_LEVEL << COEF_FRAC_BITS;
    localparam int unsigned LEVEL_LIMIT    = LEVEL_MAX << COEF_FRAC_BITS;

    localparam logic [KROW_W-1:0] KROW_TOP_RST    = KROW_W'(0);
    localparam logic [KROW_W-1:0] KROW_MIDDLE_RST = KROW_W'(48'h0000_1000_0000);
    localparam logic [KROW_W-1:0] KROW_BOTTOM_RST = KROW_W'(0);
    localparam logic [DIM_W-1:0]  WIDTH_RST       = DIM_W'(640);
    localparam logic [DIM_W-1:0]  HEIGHT_RST      = DIM_W'(480);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_KROW_TOP    = 3'd0,
        CFG_KROW_MIDDLE = 3'd1,
        CFG_KROW_BOTTOM = 3'd2,
        CFG_BIAS_ENABLE = 3'd3,
        CFG_FRAME_WIDTH = 3'd4,
        CFG_FRAME_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_gray;
        logic             frame_start;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] result_gray;
        logic [POS_W-1:0] result_row;
        logic [POS_W-1:0] result_col;
    } t_out_beat;

    // line buffer word: top goes to the row two above, mid to the row above
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
    } t_lb_pair;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    // signed q4.12 coefficient k of a packed kernel row times an unsigned pixel
    function automatic logic signed [PROD_W-1:0] coef_mul(
        input logic [KROW_W-1:0] krow,
        input logic [1:0]        k,
        input logic [PIX_W-1:0]  pix
    );
        logic signed [COEF_W-1:0]    coef;
        logic signed [PIX_W:0]       pv;
        logic signed [PROD_W:0]      full;
        coef = krow[COEF_W*k +: COEF_W];
        pv   = {1'b0, pix};
        full = coef * pv;
        return full[PROD_W-1:0];
    endfunction

endpackage

### rtl/gcf_line_buf.sv
// ----------------------------------------------------------------------------
// gcf_line_buf
// two line memories holding the rows one and two above the current pixel
// ----------------------------------------------------------------------------
module gcf_line_buf #(
    parameter int unsigned DEPTH = gcf_pkg::MAX_WIDTH_DEF,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  gcf_pkg::t_lb_pair i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output gcf_pkg::t_lb_pair o_rd_data
);

    logic [gcf_pkg::PIX_W-1:0] r_mem_above     [DEPTH];
    logic [gcf_pkg::PIX_W-1:0] r_mem_two_above [DEPTH];
    gcf_pkg::t_lb_pair         r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_above[i_wr_addr]     <= i_wr_data.mid;
            r_mem_two_above[i_wr_addr] <= i_wr_data.top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data.mid <= r_mem_above[i_rd_addr];
            r_rd_data.top <= r_mem_two_above[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/gray_conv3x3_filter_top.sv
// ----------------------------------------------------------------------------
// gray_conv3x3_filter_top
// streaming 3x3 convolution of a raster grayscale image with clamped output
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 beat
//  in        sink       i_in_valid / o_in_stall   pixel_gray, frame_start
//  out       source     o_out_valid / i_out_stall result_gray, result_row, result_col
//  cfg       sink       i_cfg_wr_en               i_cfg_addr, i_cfg_wr_data
//
//  one pixel per clock unless o_in_stall is raised; a result is registered through
//  line buffer read, nine products, then sum and clamp into the output register
//  a stalled output register holds its beat while inner stages keep filling
//  synchronous reset clears control, counters, window and config only
//  line memories are not cleared; unwritten entries feed border results only
// ----------------------------------------------------------------------------
module gray_conv3x3_filter_top #(
    parameter int unsigned MAX_WIDTH = gcf_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  gcf_pkg::t_in_beat              i_in_beat,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output gcf_pkg::t_out_beat             o_out_beat,
    input  logic                           i_cfg_wr_en,
    input  logic [gcf_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [gcf_pkg::CFG_DATA_W-1:0] i_cfg_wr_data
);

    localparam int unsigned AW   = $clog2(MAX_WIDTH);
    localparam int unsigned WLIM = (MAX_WIDTH < gcf_pkg::COUNT_LIMIT) ?
                                   MAX_WIDTH : gcf_pkg::COUNT_LIMIT;
    localparam logic [gcf_pkg::DIM_W-1:0] WLIM_V = gcf_pkg::DIM_W'(WLIM);
    localparam logic [gcf_pkg::DIM_W-1:0] HLIM_V = gcf_pkg::DIM_W'(gcf_pkg::COUNT_LIMIT);
    localparam logic [gcf_pkg::DIM_W-1:0] ONE_V  = gcf_pkg::DIM_W'(1);
    localparam logic [gcf_pkg::DIM_W-1:0] TWO_V  = gcf_pkg::DIM_W'(2);
    localparam logic signed [gcf_pkg::ACC_W-1:0] ACC_LIMIT =
        gcf_pkg::ACC_W'(gcf_pkg::LEVEL_LIMIT);
    localparam logic signed [gcf_pkg::ACC_W-1:0] ACC_BIAS =
        gcf_pkg::ACC_W'(gcf_pkg::BIAS_FIXED);

    // configuration
    logic [gcf_pkg::KROW_W-1:0] r_krow_top, r_krow_mid, r_krow_bot;
    logic                       r_bias_en;
    logic [gcf_pkg::DIM_W-1:0]  r_frame_w, r_frame_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_krow_top <= gcf_pkg::KROW_TOP_RST;
            r_krow_mid <= gcf_pkg::KROW_MIDDLE_RST;
            r_krow_bot <= gcf_pkg::KROW_BOTTOM_RST;
            r_bias_en  <= 1'b0;
            r_frame_w  <= gcf_pkg::WIDTH_RST;
            r_frame_h  <= gcf_pkg::HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                gcf_pkg::CFG_KROW_TOP:     r_krow_top <= i_cfg_wr_data;
                gcf_pkg::CFG_KROW_MIDDLE:  r_krow_mid <= i_cfg_wr_data;
                gcf_pkg::CFG_KROW_BOTTOM:  r_krow_bot <= i_cfg_wr_data;
                gcf_pkg::CFG_BIAS_ENABLE:  r_bias_en  <= i_cfg_wr_data[0];
                gcf_pkg::CFG_FRAME_WIDTH:  r_frame_w  <= i_cfg_wr_data[gcf_pkg::DIM_W-1:0];
                gcf_pkg::CFG_FRAME_HEIGHT: r_frame_h  <= i_cfg_wr_data[gcf_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    logic [gcf_pkg::DIM_W-1:0] w_eff, h_eff;

    always_comb begin
        if (r_frame_w == '0) begin
            w_eff = ONE_V;
        end else if (r_frame_w > WLIM_V) begin
            w_eff = WLIM_V;
        end else begin
            w_eff = r_frame_w;
        end
        if (r_frame_h == '0) begin
            h_eff = ONE_V;
        end else if (r_frame_h > HLIM_V) begin
            h_eff = HLIM_V;
        end else begin
            h_eff = r_frame_h;
        end
    end

    // handshake between stages
    logic r_v1, r_v2, r_out_valid;
    logic r_s1_emit;
    logic adv_o, free2, fire1, free1, accept;

    assign adv_o  = !r_out_valid || !i_out_stall;
    assign free2  = !r_v2 || adv_o;
    assign fire1  = r_v1 && (free2 || !r_s1_emit);
    assign free1  = !r_v1 || fire1;
    assign accept = i_in_valid && free1;
    assign o_in_stall = !free1;

    // position of the incoming pixel
    logic [gcf_pkg::POS_W-1:0] r_row_cnt, r_col_cnt;
    logic [gcf_pkg::DIM_W-1:0] s0_r, s0_c, n_row, n_col;
    logic                      s0_emit, s0_interior;

    always_comb begin
        if (i_in_beat.frame_start) begin
            s0_r = '0;
            s0_c = '0;
        end else begin
            s0_r = {1'b0, r_row_cnt};
            s0_c = {1'b0, r_col_cnt};
            if (s0_c >= w_eff) begin
                s0_c = '0;
                s0_r = s0_r + ONE_V;
            end
            if (s0_r >= h_eff) begin
                s0_r = '0;
            end
        end
        n_row = s0_r;
        n_col = s0_c + ONE_V;
        if (n_col >= w_eff) begin
            n_col = '0;
            n_row = n_row + ONE_V;
            if (n_row >= h_eff) begin
                n_row = '0;
            end
        end
        s0_emit     = (s0_r != '0) && (s0_c != '0);
        s0_interior = (s0_r >= TWO_V) && (s0_c >= TWO_V);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (accept) begin
            r_row_cnt <= gcf_pkg::POS_W'(n_row);
            r_col_cnt <= gcf_pkg::POS_W'(n_col);
        end
    end

    // stage 1: line buffer data arrives, window shifts, products formed
    logic [gcf_pkg::PIX_W-1:0] r_s1_pix;
    logic [gcf_pkg::POS_W-1:0] r_s1_col, r_s1_orow, r_s1_ocol;
    logic                      r_s1_interior;
    logic                      r_fwd;
    gcf_pkg::t_lb_pair         r_fwd_pair;
    gcf_pkg::t_lb_pair         rd_pair, s1_pair, wr_pair;
    gcf_pkg::t_col             r_win_1, r_win_2, s1_col0;
    logic [gcf_pkg::POS_W-1:0] s0_col;

    assign s0_col  = gcf_pkg::POS_W'(s0_c);
    assign s1_pair = r_fwd ? r_fwd_pair : rd_pair;
    assign s1_col0 = '{top: s1_pair.top, mid: s1_pair.mid, bot: r_s1_pix};
    assign wr_pair = '{top: s1_pair.mid, mid: r_s1_pix};

    gcf_line_buf #(
        .DEPTH(MAX_WIDTH)
    ) u_line_buf (
        .i_clk    (i_clk),
        .i_wr_en  (fire1),
        .i_wr_addr(AW'(r_s1_col)),
        .i_wr_data(wr_pair),
        .i_rd_en  (accept),
        .i_rd_addr(AW'(s0_col)),
        .o_rd_data(rd_pair)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_fwd <= 1'b0;
        end else begin
            if (accept) begin
                r_v1  <= 1'b1;
                r_fwd <= fire1 && (r_s1_col == s0_col);
            end else if (fire1) begin
                r_v1  <= 1'b0;
                r_fwd <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= i_in_beat.pixel_gray;
            r_s1_col      <= s0_col;
            r_s1_orow     <= gcf_pkg::POS_W'(s0_r - ONE_V);
            r_s1_ocol     <= gcf_pkg::POS_W'(s0_c - ONE_V);
            r_s1_emit     <= s0_emit;
            r_s1_interior <= s0_interior;
            r_fwd_pair    <= wr_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_1 <= '0;
            r_win_2 <= '0;
        end else if (fire1) begin
            r_win_1 <= s1_col0;
            r_win_2 <= r_win_1;
        end
    end

    // stage 2: product registers
    logic signed [gcf_pkg::PROD_W-1:0] r_prod [gcf_pkg::NUM_TAPS];
    logic signed [gcf_pkg::PROD_W-1:0] n_prod [gcf_pkg::NUM_TAPS];
    logic [gcf_pkg::POS_W-1:0]         r_s2_orow, r_s2_ocol;
    logic                              r_s2_interior;
    gcf_pkg::t_col                     cols [3];

    always_comb begin
        cols[0] = s1_col0;
        cols[1] = r_win_1;
        cols[2] = r_win_2;
        for (int k = 0; k < 3; k++) begin
            // true convolution: kernel row 0 meets the row below, column 0 the right
            n_prod[3*k]     = gcf_pkg::coef_mul(r_krow_top, 2'(k), cols[k].bot);
            n_prod[3*k + 1] = gcf_pkg::coef_mul(r_krow_mid, 2'(k), cols[k].mid);
            n_prod[3*k + 2] = gcf_pkg::coef_mul(r_krow_bot, 2'(k), cols[k].top);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= (r_v2 && !adv_o) || (fire1 && r_s1_emit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire1 && r_s1_emit) begin
            r_prod        <= n_prod;
            r_s2_orow     <= r_s1_orow;
            r_s2_ocol     <= r_s1_ocol;
            r_s2_interior <= r_s1_interior;
        end
    end

    // stage 3: sum, optional bias, clamp (zero on the border) into the output register
    logic signed [gcf_pkg::ACC_W-1:0] acc;
    logic [gcf_pkg::PIX_W-1:0]        level;
    gcf_pkg::t_out_beat               r_out;

    always_comb begin
        acc = r_bias_en ? ACC_BIAS : '0;
        for (int i = 0; i < gcf_pkg::NUM_TAPS; i++) begin
            acc = acc + gcf_pkg::ACC_W'(r_prod[i]);
        end
        if (!r_s2_interior || acc < 0) begin
            level = '0;
        end else if (acc > ACC_LIMIT) begin
            level = gcf_pkg::PIX_W'(gcf_pkg::LEVEL_MAX);
        end else begin
            level = acc[gcf_pkg::COEF_FRAC_BITS +: gcf_pkg::PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_o) begin
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_o && r_v2) begin
            r_out.result_gray <= level;
            r_out.result_row  <= r_s2_orow;
            r_out.result_col  <= r_s2_ocol;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_v1)
        else $error("line buffer bypass set with no pixel in stage 1");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_in_stall)
        else $error("input stalled while stage 1 is empty");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_beat.result_row == '0 || o_out_beat.result_col == '0))
        |-> (o_out_beat.result_gray == '0))
        else $error("border result is not zero");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !adv_o) |=> r_v2)
        else $error("stage 2 beat lost while output stalled");

endmodule

### tb/tb_gray_conv3x3_filter_top.sv
// ----------------------------------------------------------------------------
// tb_gray_conv3x3_filter_top
// self-checking bench for the 3x3 grayscale convolution filter: raster pixels
// are pushed through the block with random idle and back-pressure on both
// channels. A behavioral line-buffer and window model predicts every filtered
// beat and a monitor compares the output stream field by field.
// ----------------------------------------------------------------------------
module tb_gray_conv3x3_filter_top;

    localparam int unsigned DRAIN_CYCLES = 8;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    gcf_pkg::t_in_beat              i_in_beat;
    logic                           o_out_valid;
    logic                           i_out_stall;
    gcf_pkg::t_out_beat             o_out_beat;
    logic                           i_cfg_wr_en;
    logic [gcf_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [gcf_pkg::CFG_DATA_W-1:0] i_cfg_wr_data;

    // mirror of the filter state
    logic [gcf_pkg::KROW_W-1:0]     krow_q [3];
    logic                           bias_on;
    logic [gcf_pkg::DIM_W-1:0]      width_q;
    logic [gcf_pkg::DIM_W-1:0]      height_q;
    logic [gcf_pkg::PIX_W-1:0]      above_mem [gcf_pkg::COUNT_LIMIT];
    logic [gcf_pkg::PIX_W-1:0]      two_above_mem [gcf_pkg::COUNT_LIMIT];
    logic [gcf_pkg::PIX_W-1:0]      win [6];
    int unsigned                    row_pos;
    int unsigned                    col_pos;

    gcf_pkg::t_out_beat             filtered_q [$];
    gcf_pkg::t_out_beat             want_beat;

    bit                             in_gaps_on;
    bit                             out_gaps_on;
    int                             hold_left;
    int                             burst_left;

    int                             pixels_sent;
    int                             results_checked;
    int                             cfg_writes;
    int                             in_stall_cycles;
    int                             mismatch_count;

    gray_conv3x3_filter_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_beat     (i_in_beat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_beat    (o_out_beat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned clip_dim(input logic [gcf_pkg::DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > gcf_pkg::COUNT_LIMIT) return gcf_pkg::COUNT_LIMIT;
        return v;
    endfunction

    function automatic longint coef_of(input logic [gcf_pkg::KROW_W-1:0] row, input int k);
        logic signed [gcf_pkg::COEF_W-1:0] cf;
        cf = row[gcf_pkg::COEF_W*k +: gcf_pkg::COEF_W];
        return longint'(cf);
    endfunction

    // tap[age][0 top, 1 mid, 2 bottom]; age 0 is the newest column
    function automatic void convolve_pixel(input logic [gcf_pkg::PIX_W-1:0] pix, input logic fs);
        int unsigned        w;
        int unsigned        h;
        int unsigned        r;
        int unsigned        c;
        int                 k;
        logic [7:0]         top;
        logic [7:0]         mid;
        logic [7:0]         tap [3][3];
        longint             acc;
        gcf_pkg::t_out_beat beat;
        w = clip_dim(width_q);
        h = clip_dim(height_q);
        if (fs) begin
            r = 0;
            c = 0;
        end else begin
            r = row_pos;
            c = col_pos;
            if (c >= w) begin
                c = 0;
                r++;
            end
            if (r >= h) r = 0;
        end
        top = two_above_mem[c];
        mid = above_mem[c];
        if (r >= 1 && c >= 1) begin
            beat.result_gray = '0;
            beat.result_row  = gcf_pkg::POS_W'(r - 1);
            beat.result_col  = gcf_pkg::POS_W'(c - 1);
            if (r >= 2 && c >= 2 && r < h && c < w) begin
                tap[0][0] = top;
                tap[0][1] = mid;
                tap[0][2] = pix;
                for (k = 0; k < 3; k++) begin
                    tap[1][k] = win[k];
                    tap[2][k] = win[3 + k];
                end
                acc = 0;
                for (k = 0; k < 3; k++) begin
                    acc += coef_of(krow_q[0], k) * longint'(tap[k][2]);
                    acc += coef_of(krow_q[1], k) * longint'(tap[k][1]);
                    acc += coef_of(krow_q[2], k) * longint'(tap[k][0]);
                end
                if (bias_on) acc += longint'(gcf_pkg::BIAS_FIXED);
                if (acc < 0) beat.result_gray = '0;
                else if (acc > longint'(gcf_pkg::LEVEL_LIMIT))
                    beat.result_gray = gcf_pkg::PIX_W'(gcf_pkg::LEVEL_MAX);
                else beat.result_gray = gcf_pkg::PIX_W'(acc >>> gcf_pkg::COEF_FRAC_BITS);
            end
            filtered_q.push_back(beat);
        end
        for (k = 0; k < 3; k++) win[3 + k] = win[k];
        win[0] = top;
        win[1] = mid;
        win[2] = pix;
        two_above_mem[c] = mid;
        above_mem[c]     = pix;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endfunction

    function automatic logic [gcf_pkg::KROW_W-1:0] random_krow();
        logic [gcf_pkg::KROW_W-1:0] row;
        int                         k;
        for (k = 0; k < 3; k++) begin
            if ($urandom_range(0, 3) == 0) row[16*k +: 16] = 16'($urandom);
            else row[16*k +: 16] = 16'($urandom_range(0, 16'h0800)) - 16'h0400;
        end
        return row;
    endfunction

    function automatic logic [gcf_pkg::PIX_W-1:0] random_level();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // oversized values only where asked, so rows stay within the filled columns
    function automatic logic [gcf_pkg::CFG_DATA_W-1:0] random_dim(input bit allow_over);
        int sel;
        int dim;
        sel = $urandom_range(0, 15);
        if (sel == 0) dim = $urandom_range(0, 2);
        else if (sel == 1 && allow_over) dim = $urandom_range(2049, 4095);
        else if (sel < 5) dim = $urandom_range(13, 40);
        else dim = $urandom_range(3, 12);
        // upper data bits are don't-care for the geometry registers
        return {$urandom, 4'($urandom), 12'(dim)};
    endfunction

    task automatic note_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic write_reg(input gcf_pkg::t_cfg_idx idx, input logic [gcf_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= idx;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        case (idx)
            gcf_pkg::CFG_KROW_TOP:     krow_q[0] = val;
            gcf_pkg::CFG_KROW_MIDDLE:  krow_q[1] = val;
            gcf_pkg::CFG_KROW_BOTTOM:  krow_q[2] = val;
            gcf_pkg::CFG_BIAS_ENABLE:  bias_on   = val[0];
            gcf_pkg::CFG_FRAME_WIDTH:  width_q   = val[gcf_pkg::DIM_W-1:0];
            gcf_pkg::CFG_FRAME_HEIGHT: height_q  = val[gcf_pkg::DIM_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic write_kernel(input logic [47:0] top, input logic [47:0] mid,
                                input logic [47:0] bot, input logic bias);
        write_reg(gcf_pkg::CFG_KROW_TOP, top);
        write_reg(gcf_pkg::CFG_KROW_MIDDLE, mid);
        write_reg(gcf_pkg::CFG_KROW_BOTTOM, bot);
        write_reg(gcf_pkg::CFG_BIAS_ENABLE, {$urandom, 15'($urandom), bias});
    endtask

    task automatic write_geometry(input logic [47:0] w, input logic [47:0] h);
        write_reg(gcf_pkg::CFG_FRAME_WIDTH, w);
        write_reg(gcf_pkg::CFG_FRAME_HEIGHT, h);
    endtask

    task automatic send_pixel(input logic [gcf_pkg::PIX_W-1:0] pix, input logic fs);
        gcf_pkg::t_in_beat beat;
        beat.pixel_gray  = pix;
        beat.frame_start = fs;
        @(negedge i_clk);
        if (in_gaps_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        convolve_pixel(pix, fs);
        pixels_sent++;
    endtask

    task automatic send_run(input int n, input logic mark);
        int i;
        for (i = 0; i < n; i++) send_pixel(random_level(), (i == 0) ? mark : 1'b0);
    endtask

    // block must be idle before any register write
    task automatic finish_phase();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // no beat inside the first default row, then the identity kernel on rows
    // that also write every line buffer column the later tests reach
    task automatic test_reset_defaults();
        send_run(24, 1'b0);
        finish_phase();
        write_geometry(48'd64, 48'd8);
        send_run(2 * 64 + 6, 1'b1);
        finish_phase();
    endtask

    task automatic test_saturated_geometry();
        write_geometry($urandom_range(0, 1) ? 48'd2048 : 48'hFFF, 48'd3);
        write_kernel(random_krow(), random_krow(), random_krow(), 1'b1);
        send_run(40, 1'b1);
        finish_phase();
        write_geometry(48'd8, $urandom_range(0, 1) ? 48'd2048 : 48'hFFF);
        send_run(8 * 4 + 2, 1'b1);
        finish_phase();
    endtask

    task automatic test_kernel_extremes();
        int s;
        int i;
        write_geometry(48'd3, 48'd3);
        for (s = 0; s < 3; s++) begin
            case (s)
                0: write_kernel(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 1'b0);
                1: write_kernel(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 1'b1);
                default: write_kernel(48'h0000_0000_1000, 48'd0, 48'd0, 1'b1);
            endcase
            // last setting picks out the bottom-right neighbour plus bias
            for (i = 0; i < 9; i++)
                send_pixel((s < 2) ? 8'hFF : 8'(10 * i), i == 0);
            finish_phase();
        end
    endtask

    task automatic test_degenerate_geometry();
        write_geometry(48'd0, {$urandom, 16'h0000});
        send_run(4, $urandom_range(0, 1));
        finish_phase();
        write_geometry(48'd1, 48'd6);
        send_run(6, 1'b1);
        finish_phase();
        write_geometry(48'd7, 48'd1);
        send_run(9, 1'b0);
        finish_phase();
        write_geometry(48'd3, 48'd0);
        send_run(4, 1'b0);
        finish_phase();
    endtask

    task automatic test_mid_frame_geometry();
        write_geometry(48'd6, 48'd6);
        write_kernel(random_krow(), random_krow(), random_krow(), 1'b0);
        send_run(14, 1'b1);
        finish_phase();
        write_reg(gcf_pkg::CFG_FRAME_WIDTH, 48'd4);
        send_run(8, 1'b0);
        finish_phase();
        write_reg(gcf_pkg::CFG_FRAME_HEIGHT, 48'd2);
        send_run(5, 1'b0);
        finish_phase();
        write_geometry(48'd10, 48'd7);
        send_run(20, 1'b0);
        finish_phase();
    endtask

    task automatic test_backpressure();
        write_geometry(48'd8, 48'd8);
        write_kernel(random_krow(), random_krow(), random_krow(), $urandom_range(0, 1));
        in_gaps_on = 1'b0;
        hold_left  = 250;
        send_run(80, 1'b1);
        finish_phase();
        in_gaps_on = 1'b1;
    endtask

    // mostly whole frames with random content, some cut short or left unmarked
    task automatic test_random_frames(input int budget);
        int sent;
        int n;
        int phase_len;
        int frame_len;
        int cut;
        int i;
        bit mark;
        sent = 0;
        while (sent < budget) begin
            write_geometry(random_dim(1'b0), random_dim(1'b1));
            write_kernel(random_krow(), random_krow(), random_krow(), $urandom_range(0, 1));
            frame_len = clip_dim(width_q) * clip_dim(height_q);
            phase_len = $urandom_range(50, 130);
            n = 0;
            while (n < phase_len) begin
                cut  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, frame_len) : frame_len;
                mark = $urandom_range(0, 3) != 0;
                for (i = 0; i < cut && n < phase_len; i++) begin
                    send_pixel(random_level(), (i == 0 && mark) || $urandom_range(0, 99) == 0);
                    n++;
                end
            end
            finish_phase();
            sent += n;
        end
    endtask

    task automatic test_steady_stream();
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        write_geometry(48'($urandom_range(3, 16)), 48'($urandom_range(3, 16)));
        write_kernel(random_krow(), random_krow(), random_krow(), $urandom_range(0, 1));
        send_run(150, 1'b1);
        finish_phase();
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (out_gaps_on && $urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(0, 16);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall) in_stall_cycles++;
            if (o_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat row %0d col %0d gray %0d",
                                  o_out_beat.result_row, o_out_beat.result_col,
                                  o_out_beat.result_gray));
                end else begin
                    want_beat = filtered_q.pop_front();
                    if (o_out_beat.result_row !== want_beat.result_row)
                        note_mismatch($sformatf("row %0d, want %0d",
                                      o_out_beat.result_row, want_beat.result_row));
                    if (o_out_beat.result_col !== want_beat.result_col)
                        note_mismatch($sformatf("col %0d, want %0d",
                                      o_out_beat.result_col, want_beat.result_col));
                    if (o_out_beat.result_gray !== want_beat.result_gray)
                        note_mismatch($sformatf("gray %0d, want %0d at (%0d,%0d)",
                                      o_out_beat.result_gray, want_beat.result_gray,
                                      want_beat.result_row, want_beat.result_col));
                    results_checked++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb_gray_conv3x3_filter_top: FAIL");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_beat     = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wr_data = '0;
        krow_q[0]     = gcf_pkg::KROW_TOP_RST;
        krow_q[1]     = gcf_pkg::KROW_MIDDLE_RST;
        krow_q[2]     = gcf_pkg::KROW_BOTTOM_RST;
        bias_on       = 1'b0;
        width_q       = gcf_pkg::WIDTH_RST;
        height_q      = gcf_pkg::HEIGHT_RST;
        win           = '{default: '0};
        row_pos       = 0;
        col_pos       = 0;
        in_gaps_on    = 1'b1;
        out_gaps_on   = 1'b1;
        hold_left     = 0;
        burst_left    = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_saturated_geometry();
        test_kernel_extremes();
        test_degenerate_geometry();
        test_mid_frame_geometry();
        test_backpressure();
        test_random_frames(300);
        test_steady_stream();

        $display("summary: %0d pixels sent, %0d filtered beats checked, %0d register writes",
                 pixels_sent, results_checked, cfg_writes);
        $display("summary: %0d input back-pressure cycles; reset, saturated, kernel, %s",
                 in_stall_cycles, "degenerate and mid-frame geometry cases run");
        if (mismatch_count == 0 && filtered_q.size() == 0)
            $display("tb_gray_conv3x3_filter_top: PASS");
        else
            $display("tb_gray_conv3x3_filter_top: FAIL");
        $finish;
    end

endmodule
